### hw/rtl/hlm_pkg.sv
// ----------------------------------------------------------------------------
// hlm_pkg
// Shared constants, codes and types of the heartbeat liveness monitor.
// ----------------------------------------------------------------------------
package hlm_pkg;

    localparam int NODES_DEF     = 32;
    localparam int TIME_BITS_DEF = 48;

    // fixed field widths
    localparam int MODE_W     = 4;
    localparam int NODE_W     = 5;
    localparam int STATUS_W   = 3;
    localparam int NSTATE_W   = 2;
    localparam int MISS_W     = 8;
    localparam int PERIOD_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    // widest node index the recency list carries (up to 64 nodes)
    localparam int ID_MAX_W   = 6;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd15000000;
    localparam logic [MISS_W-1:0]   ALLOW_RESET  = 8'd2;
    localparam logic [MISS_W-1:0]   MISS_MAX     = 8'hFF;

    // event codes
    localparam logic [MODE_W-1:0] MODE_ADD        = 4'd0;
    localparam logic [MODE_W-1:0] MODE_LOGIN      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_LOGOUT     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MARK_EXP   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_FORCE_EXP  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_BEAT       = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CHECK      = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BEAT_ALL   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_OLD_MASTER = 4'd8;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 4'd9;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_CHANGE  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_ALLOWED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EXPIRED     = 3'd4;

    // node states
    localparam logic [NSTATE_W-1:0] NS_OUT = 2'd0;
    localparam logic [NSTATE_W-1:0] NS_IN  = 2'd1;
    localparam logic [NSTATE_W-1:0] NS_EXP = 2'd2;
    localparam logic [NSTATE_W-1:0] NS_OM  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW  = 1'b1;

    // command to the recency list
    typedef struct packed {
        logic                rem_en;
        logic                app_en;
        logic [ID_MAX_W-1:0] id;
        logic                snap_load;
        logic                snap_shift;
    } lcmd_t;

endpackage

### hw/rtl/heartbeat_liveness_monitor.sv
// ----------------------------------------------------------------------------
// heartbeat_liveness_monitor
// Per-node liveness table with delay statistics, a recency list and a
// timeout walk over the least recent logged-in nodes.
// ----------------------------------------------------------------------------
//  channel | signals                                   | beat moves
//  --------+-------------------------------------------+------------------
//  in      | in_valid/in_ready, mode, node, now        | one event
//  out     | out_valid/out_ready, status .. final_res  | one result
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | one register write
//
//  A single-node event moves through exec and emit to wait, and ready returns
//  once its result is taken. Check and beat-all visit one node at a time, with
//  emit and wait per result; all table work goes through one table read port.
//  Reset clears valid bits and the list count; no clearing pass is needed.
//  A stalled result holds the block; no event is taken while results remain.
// ----------------------------------------------------------------------------
module heartbeat_liveness_monitor #(
    parameter int NODES     = hlm_pkg::NODES_DEF,
    parameter int TIME_BITS = hlm_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [hlm_pkg::MODE_W-1:0]       mode,
    input  logic [hlm_pkg::NODE_W-1:0]       node,
    input  logic [TIME_BITS-1:0]             now,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [hlm_pkg::STATUS_W-1:0]     status,
    output logic [hlm_pkg::NODE_W-1:0]       node_id,
    output logic [hlm_pkg::NSTATE_W-1:0]     node_state,
    output logic [hlm_pkg::NSTATE_W-1:0]     prior_state,
    output logic [hlm_pkg::MISS_W-1:0]       miss_count,
    output logic [TIME_BITS-1:0]             average_delay,
    output logic [TIME_BITS-1:0]             longest_delay,
    output logic                             final_res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hlm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hlm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hlm_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_BALL,
        S_EMIT,
        S_WAIT
    } fsm_t;

    fsm_t state_reg, state_next, cont_reg, cont_next;

    // configuration
    logic [PERIOD_W-1:0] period_reg;
    logic [MISS_W-1:0]   allow_reg;

    // latched event
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [TIME_BITS-1:0] now_reg, now_next;

    // pending result descriptor
    logic [STATUS_W-1:0] rstat_reg, rstat_next;
    logic [IDX_W-1:0]    rix_reg, rix_next;
    logic                rshow_reg, rshow_next;
    logic                rfinal_reg, rfinal_next;

    // walk and scan
    logic [CNT_W-1:0]     wcnt_reg, wcnt_next;
    logic [CNT_W-1:0]     wn_reg, wn_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [TIME_BITS-1:0] lct_reg, lct_next;

    // output register
    logic                 ov_reg, ov_next;
    logic [STATUS_W-1:0]  ostat_reg, ostat_next;
    logic [NODE_W-1:0]    oid_reg, oid_next;
    logic [NSTATE_W-1:0]  ost_reg, ost_next;
    logic [NSTATE_W-1:0]  opr_reg, opr_next;
    logic [MISS_W-1:0]    omiss_reg, omiss_next;
    logic [TIME_BITS-1:0] oavg_reg, oavg_next;
    logic [TIME_BITS-1:0] olong_reg, olong_next;
    logic                 ofin_reg, ofin_next;

    // node table
    logic                 valid_reg  [NODES];
    logic                 inrec_reg  [NODES];
    logic [NSTATE_W-1:0]  st_mem     [NODES];
    logic [NSTATE_W-1:0]  pr_mem     [NODES];
    logic [MISS_W-1:0]    miss_mem   [NODES];
    logic [TIME_BITS-1:0] last_mem   [NODES];
    logic [TIME_BITS-1:0] avg_mem    [NODES];
    logic [TIME_BITS-1:0] long_mem   [NODES];

    logic [IDX_W-1:0]     rd_ix;
    logic [IDX_W-1:0]     node_ix;
    logic                 in_range;
    logic                 known;
    logic                 cur_valid;
    logic                 cur_inrec;
    logic [NSTATE_W-1:0]  cur_st;
    logic [NSTATE_W-1:0]  cur_pr;
    logic [MISS_W-1:0]    cur_miss;
    logic [TIME_BITS-1:0] cur_last;
    logic [TIME_BITS-1:0] cur_avg;
    logic [TIME_BITS-1:0] cur_long;
    logic                 cur_login;

    logic [TIME_BITS:0]   bdiff;
    logic [TIME_BITS-1:0] delay;
    logic                 late;
    logic [TIME_BITS-1:0] beat_avg;
    logic [TIME_BITS-1:0] beat_long;
    logic [TIME_BITS:0]   cdiff;
    logic                 check_due;
    logic [MISS_W-1:0]    miss_inc;

    logic                 wr_en;
    logic                 valid_set;
    logic                 om_en;
    logic [NSTATE_W-1:0]  n_st;
    logic [NSTATE_W-1:0]  n_pr;
    logic [MISS_W-1:0]    n_miss;
    logic [TIME_BITS-1:0] n_last;
    logic [TIME_BITS-1:0] n_avg;
    logic [TIME_BITS-1:0] n_long;
    lcmd_t                lcmd;
    logic [CNT_W-1:0]     lcount;
    logic [IDX_W-1:0]     head_ix;

    assign node_ix  = IDX_W'(node_reg);
    assign in_range = (32'(node_reg) < NODES);
    assign known    = in_range && valid_reg[node_ix];

    // pick the one table row this cycle works on
    always_comb
    begin
        unique case (state_reg)
            S_WALK:  rd_ix = head_ix;
            S_BALL:  rd_ix = scan_reg[IDX_W-1:0];
            S_EMIT:  rd_ix = rix_reg;
            default: rd_ix = node_ix;
        endcase
    end

    assign cur_valid = valid_reg[rd_ix];
    assign cur_inrec = inrec_reg[rd_ix];
    assign cur_st    = st_mem[rd_ix];
    assign cur_pr    = pr_mem[rd_ix];
    assign cur_miss  = miss_mem[rd_ix];
    assign cur_last  = last_mem[rd_ix];
    assign cur_avg   = avg_mem[rd_ix];
    assign cur_long  = long_mem[rd_ix];
    assign cur_login = (cur_st == NS_IN) || (cur_st == NS_OM);

    // delay since last beat, wrapping; late when strictly past the period
    assign bdiff = {1'b0, now_reg} - {1'b0, cur_last};
    assign delay = bdiff[TIME_BITS-1:0];
    assign late  = !bdiff[TIME_BITS] && (delay != '0)
                   && (delay > TIME_BITS'(period_reg));

    // halving average and running maximum
    always_comb
    begin
        if (cur_avg != '0)
        begin
            beat_avg = (cur_avg >> 1) + (delay >> 1)
                       + TIME_BITS'(cur_avg[0] & delay[0]);
        end
        else
        begin
            beat_avg = delay;
        end
        beat_long = (delay > cur_long) ? delay : cur_long;
    end

    assign cdiff     = {1'b0, now_reg} - {1'b0, lct_reg};
    assign check_due = !cdiff[TIME_BITS] && (cdiff[TIME_BITS-1:0] != '0)
                       && (cdiff[TIME_BITS-1:0] > TIME_BITS'(period_reg >> 1));
    assign miss_inc  = (cur_miss == MISS_MAX) ? MISS_MAX : cur_miss + MISS_W'(1);

    // event sequencing and table update values
    always_comb
    begin
        state_next  = state_reg;
        cont_next   = cont_reg;
        mode_next   = mode_reg;
        node_next   = node_reg;
        now_next    = now_reg;
        rstat_next  = rstat_reg;
        rix_next    = rix_reg;
        rshow_next  = rshow_reg;
        rfinal_next = rfinal_reg;
        wcnt_next   = wcnt_reg;
        wn_next     = wn_reg;
        scan_next   = scan_reg;
        lct_next    = lct_reg;
        ov_next     = ov_reg;
        ostat_next  = ostat_reg;
        oid_next    = oid_reg;
        ost_next    = ost_reg;
        opr_next    = opr_reg;
        omiss_next  = omiss_reg;
        oavg_next   = oavg_reg;
        olong_next  = olong_reg;
        ofin_next   = ofin_reg;
        wr_en       = 1'b0;
        valid_set   = 1'b0;
        om_en       = 1'b0;
        n_st        = cur_st;
        n_pr        = cur_pr;
        n_miss      = cur_miss;
        n_last      = cur_last;
        n_avg       = cur_avg;
        n_long      = cur_long;
        lcmd        = '0;
        lcmd.id     = ID_MAX_W'(rd_ix);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    node_next  = node;
                    now_next   = now;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                rix_next    = node_ix;
                rshow_next  = 1'b1;
                rfinal_next = 1'b1;
                rstat_next  = STAT_OK;
                state_next  = S_EMIT;
                if ((((mode_reg >= MODE_LOGIN) && (mode_reg <= MODE_BEAT))
                     || (mode_reg == MODE_QUERY)) && !known)
                begin
                    rstat_next = STAT_UNKNOWN;
                    rshow_next = 1'b0;
                end
                else
                begin
                    case (mode_reg)
                        MODE_ADD:
                        begin
                            if (!in_range)
                            begin
                                rstat_next = STAT_UNKNOWN;
                                rshow_next = 1'b0;
                            end
                            else if (!cur_valid)
                            begin
                                wr_en       = 1'b1;
                                valid_set   = 1'b1;
                                n_st        = NS_OUT;
                                n_pr        = NS_OUT;
                                n_miss      = '0;
                                n_last      = '0;
                                n_avg       = '0;
                                n_long      = '0;
                                lcmd.rem_en = cur_inrec;
                            end
                        end
                        MODE_LOGIN:
                        begin
                            if ((cur_st != NS_OUT) && (cur_st != NS_OM))
                            begin
                                rstat_next = STAT_BAD_CHANGE;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                n_pr        = cur_st;
                                n_st        = NS_IN;
                                lcmd.rem_en = cur_inrec;
                                lcmd.app_en = 1'b1;
                            end
                        end
                        MODE_LOGOUT, MODE_MARK_EXP:
                        begin
                            wr_en       = 1'b1;
                            n_pr        = cur_st;
                            n_st        = (mode_reg == MODE_LOGOUT) ? NS_OUT : NS_EXP;
                            lcmd.rem_en = cur_inrec;
                        end
                        MODE_FORCE_EXP:
                        begin
                            wr_en       = 1'b1;
                            n_st        = NS_EXP;
                            lcmd.rem_en = cur_inrec;
                        end
                        MODE_BEAT:
                        begin
                            if (!cur_login)
                            begin
                                rstat_next = STAT_NOT_ALLOWED;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (cur_last != '0)
                                begin
                                    n_avg  = beat_avg;
                                    n_long = beat_long;
                                end
                                n_last      = now_reg;
                                n_miss      = '0;
                                lcmd.rem_en = cur_inrec;
                                lcmd.app_en = 1'b1;
                            end
                        end
                        MODE_CHECK:
                        begin
                            rshow_next = 1'b0;
                            rix_next   = '0;
                            if (check_due)
                            begin
                                lct_next       = now_reg;
                                lcmd.snap_load = 1'b1;
                                wn_next        = lcount;
                                wcnt_next      = '0;
                                state_next     = S_WALK;
                            end
                        end
                        MODE_BEAT_ALL:
                        begin
                            scan_next  = '0;
                            state_next = S_BALL;
                        end
                        MODE_OLD_MASTER:
                        begin
                            om_en      = 1'b1;
                            rshow_next = 1'b0;
                            rix_next   = '0;
                        end
                        MODE_QUERY:
                        begin
                        end
                        default:
                        begin
                            rstat_next = STAT_NOT_ALLOWED;
                            rshow_next = 1'b0;
                            rix_next   = '0;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                rix_next    = head_ix;
                rshow_next  = 1'b0;
                rfinal_next = 1'b1;
                rstat_next  = STAT_OK;
                if (wcnt_reg == wn_reg)
                begin
                    rix_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    lcmd.snap_shift = 1'b1;
                    wcnt_next       = wcnt_reg + CNT_W'(1);
                    if (cur_login)
                    begin
                        if (!late)
                        begin
                            rix_next   = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            // count the miss, restamp, then requeue or expire
                            wr_en       = 1'b1;
                            n_miss      = miss_inc;
                            n_last      = now_reg;
                            lcmd.rem_en = cur_inrec;
                            lcmd.app_en = 1'b1;
                            rshow_next  = 1'b1;
                            rfinal_next = 1'b0;
                            if (miss_inc > allow_reg)
                            begin
                                n_st        = NS_EXP;
                                lcmd.app_en = 1'b0;
                                rstat_next  = STAT_EXPIRED;
                            end
                            cont_next  = S_WALK;
                            state_next = S_EMIT;
                        end
                    end
                end
            end

            S_BALL:
            begin
                rix_next    = scan_reg[IDX_W-1:0];
                rshow_next  = 1'b0;
                rfinal_next = 1'b1;
                rstat_next  = STAT_OK;
                if (32'(scan_reg) == NODES)
                begin
                    rix_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                    if (cur_valid && cur_login)
                    begin
                        wr_en = 1'b1;
                        if (cur_last != '0)
                        begin
                            n_avg  = beat_avg;
                            n_long = beat_long;
                        end
                        n_last      = now_reg;
                        n_miss      = '0;
                        lcmd.rem_en = cur_inrec;
                        lcmd.app_en = 1'b1;
                        rshow_next  = 1'b1;
                        rfinal_next = 1'b0;
                        cont_next   = S_BALL;
                        state_next  = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                ov_next    = 1'b1;
                ostat_next = rstat_reg;
                ofin_next  = rfinal_reg;
                if (rshow_reg)
                begin
                    oid_next   = NODE_W'(rix_reg);
                    ost_next   = cur_st;
                    opr_next   = cur_pr;
                    omiss_next = cur_miss;
                    oavg_next  = cur_avg;
                    olong_next = cur_long;
                end
                else
                begin
                    oid_next   = '0;
                    ost_next   = NS_OUT;
                    opr_next   = NS_OUT;
                    omiss_next = '0;
                    oavg_next  = '0;
                    olong_next = '0;
                end
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                if (out_ready)
                begin
                    ov_next    = 1'b0;
                    state_next = rfinal_reg ? S_IDLE : cont_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold control state, the output valid bit and the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cont_reg   <= S_IDLE;
            ov_reg     <= 1'b0;
            rfinal_reg <= 1'b1;
            wcnt_reg   <= '0;
            wn_reg     <= '0;
            scan_reg   <= '0;
            lct_reg    <= '0;
            period_reg <= PERIOD_RESET;
            allow_reg  <= ALLOW_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            cont_reg   <= cont_next;
            ov_reg     <= ov_next;
            rfinal_reg <= rfinal_next;
            wcnt_reg   <= wcnt_next;
            wn_reg     <= wn_next;
            scan_reg   <= scan_next;
            lct_reg    <= lct_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    REG_ALLOW:  allow_reg  <= cfg_data[MISS_W-1:0];
                    default:    period_reg <= period_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        node_reg  <= node_next;
        now_reg   <= now_next;
        rstat_reg <= rstat_next;
        rix_reg   <= rix_next;
        rshow_reg <= rshow_next;
        ostat_reg <= ostat_next;
        oid_reg   <= oid_next;
        ost_reg   <= ost_next;
        opr_reg   <= opr_next;
        omiss_reg <= omiss_next;
        oavg_reg  <= oavg_next;
        olong_reg <= olong_next;
        ofin_reg  <= ofin_next;
    end

    // valid and list-membership bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                valid_reg[i] <= 1'b0;
                inrec_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (valid_set)
            begin
                valid_reg[rd_ix] <= 1'b1;
            end
            if (lcmd.app_en)
            begin
                inrec_reg[rd_ix] <= 1'b1;
            end
            else if (lcmd.rem_en)
            begin
                inrec_reg[rd_ix] <= 1'b0;
            end
        end
    end

    // table rows; old master sweeps every row at once
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            st_mem[rd_ix]   <= n_st;
            pr_mem[rd_ix]   <= n_pr;
            miss_mem[rd_ix] <= n_miss;
            last_mem[rd_ix] <= n_last;
            avg_mem[rd_ix]  <= n_avg;
            long_mem[rd_ix] <= n_long;
        end
        if (om_en)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                if (valid_reg[i] && (st_mem[i] == NS_IN))
                begin
                    pr_mem[i] <= NS_IN;
                    st_mem[i] <= NS_OM;
                end
            end
        end
    end

    hlm_list #(
        .NODES (NODES),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (lcmd),
        .count     (lcount),
        .head_snap (head_ix)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = ov_reg;
    assign status        = ostat_reg;
    assign node_id       = oid_reg;
    assign node_state    = ost_reg;
    assign prior_state   = opr_reg;
    assign miss_count    = omiss_reg;
    assign average_delay = oavg_reg;
    assign longest_delay = olong_reg;
    assign final_res     = ofin_reg;

endmodule

### hw/rtl/hlm_cell.sv
// ----------------------------------------------------------------------------
// hlm_cell
// One slot of the recency list: holds a node index and a snapshot copy,
// closes gaps by taking its right neighbor's index.
// ----------------------------------------------------------------------------
module hlm_cell #(
    parameter int IDX_W = 5,
    parameter int CNT_W = 6,
    parameter int POS   = 0
) (
    input  logic               clk,
    input  hlm_pkg::lcmd_t     cmd,
    input  logic [CNT_W-1:0]   slot,
    input  logic               hit_in,
    input  logic [IDX_W-1:0]   next_id,
    input  logic [IDX_W-1:0]   next_snap,
    output logic               hit_out,
    output logic [IDX_W-1:0]   id,
    output logic [IDX_W-1:0]   snap
);
    import hlm_pkg::*;

    logic [IDX_W-1:0] id_reg;
    logic [IDX_W-1:0] id_next;
    logic [IDX_W-1:0] snap_reg;
    logic [IDX_W-1:0] snap_next;

    // pass the removal mark on to the right
    assign hit_out = hit_in | (cmd.rem_en && (id_reg == IDX_W'(cmd.id)));

    always_comb
    begin
        id_next = id_reg;
        if (hit_out)
        begin
            id_next = next_id;
        end
        if (cmd.app_en && (slot == CNT_W'(POS)))
        begin
            id_next = IDX_W'(cmd.id);
        end
        snap_next = snap_reg;
        if (cmd.snap_load)
        begin
            snap_next = id_reg;
        end
        else if (cmd.snap_shift)
        begin
            snap_next = next_snap;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        snap_reg <= snap_next;
    end

    assign id   = id_reg;
    assign snap = snap_reg;

endmodule

### hw/rtl/hlm_list.sv
// ----------------------------------------------------------------------------
// hlm_list
// Recency list of logged-in nodes, least recent at slot zero, built as a
// row of cells with a fill count.
// ----------------------------------------------------------------------------
module hlm_list #(
    parameter int NODES = hlm_pkg::NODES_DEF,
    parameter int IDX_W = 5,
    parameter int CNT_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hlm_pkg::lcmd_t   cmd,
    output logic [CNT_W-1:0] count,
    output logic [IDX_W-1:0] head_snap
);
    import hlm_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] slot;
    logic [NODES:0]   hits;
    logic [IDX_W-1:0] ids   [NODES+1];
    logic [IDX_W-1:0] snaps [NODES+1];

    // append lands one slot lower when the node leaves its old place
    assign slot = count_reg - CNT_W'(cmd.rem_en);

    always_comb
    begin
        count_next = slot;
        if (cmd.app_en)
        begin
            count_next = slot + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign hits[0]      = 1'b0;
    assign ids[NODES]   = '0;
    assign snaps[NODES] = '0;

    for (genvar g = 0; g < NODES; g++)
    begin : g_cell
        hlm_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .POS   (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .slot      (slot),
            .hit_in    (hits[g]),
            .next_id   (ids[g+1]),
            .next_snap (snaps[g+1]),
            .hit_out   (hits[g+1]),
            .id        (ids[g]),
            .snap      (snaps[g])
        );
    end

    assign count     = count_reg;
    assign head_snap = snaps[0];

endmodule

### hw/rtl/hlm_checker.sv
// ----------------------------------------------------------------------------
// hlm_checker
// Port-level checks of the heartbeat liveness monitor, bound to the top.
// ----------------------------------------------------------------------------
module hlm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [hlm_pkg::STATUS_W-1:0]  status,
    input logic [hlm_pkg::NODE_W-1:0]    node_id,
    input logic [hlm_pkg::NSTATE_W-1:0]  node_state,
    input logic [hlm_pkg::MISS_W-1:0]    miss_count,
    input logic                          final_res
);
    import hlm_pkg::*;

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(node_id)
                                    && $stable(final_res))
        else $error("result changed while stalled");

    // no event taken while a result is pending
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("event accepted with result pending");

    // unknown node gives a single, empty result
    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_UNKNOWN)
        |-> final_res && (node_state == NS_OUT) && (miss_count == '0))
        else $error("unknown-node result not empty");

    // per-node results of a walk are ok or expired
    a_walk_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !final_res |-> (status == STAT_OK) || (status == STAT_EXPIRED))
        else $error("bad status on intermediate result");

endmodule

bind heartbeat_liveness_monitor hlm_checker u_hlm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .node_id    (node_id),
    .node_state (node_state),
    .miss_count (miss_count),
    .final_res  (final_res)
);

### sim/hlm_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlm_result_checker
// Watches the event, result and register channels of the heartbeat liveness
// monitor, keeps its own copy of the node table and recency list, predicts
// every result of each accepted event and compares the results in order.
// ----------------------------------------------------------------------------
module hlm_result_checker
    import hlm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [MODE_W-1:0]       mode,
    input  logic [NODE_W-1:0]       node,
    input  logic [TIME_BITS_DEF-1:0] now,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [STATUS_W-1:0]     status,
    input  logic [NODE_W-1:0]       node_id,
    input  logic [NSTATE_W-1:0]     node_state,
    input  logic [NSTATE_W-1:0]     prior_state,
    input  logic [MISS_W-1:0]       miss_count,
    input  logic [TIME_BITS_DEF-1:0] average_delay,
    input  logic [TIME_BITS_DEF-1:0] longest_delay,
    input  logic                    final_res,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      pending,
    output int                      mismatches,
    output int                      results_seen
);

    localparam int NN = NODES_DEF;
    localparam int TW = TIME_BITS_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   id;
        logic [NSTATE_W-1:0] state;
        logic [NSTATE_W-1:0] prior;
        logic [MISS_W-1:0]   misses;
        logic [TW-1:0]       avg;
        logic [TW-1:0]       longest;
        logic                last;
    } node_result_t;

    node_result_t expected_results[$];

    // predicted configuration and table
    logic [PERIOD_W-1:0] period;
    logic [MISS_W-1:0]   allow;
    logic                known    [NN];
    logic [NSTATE_W-1:0] nstate   [NN];
    logic [NSTATE_W-1:0] nprior   [NN];
    logic [MISS_W-1:0]   nmiss    [NN];
    logic [TW-1:0]       beat_stamp[NN];
    logic [TW-1:0]       avg_gap  [NN];
    logic [TW-1:0]       max_gap  [NN];
    logic                listed   [NN];
    int                  recency[$];
    logic [TW-1:0]       last_check;

    function automatic logic is_live(int idx);
        return nstate[idx] == NS_IN || nstate[idx] == NS_OM;
    endfunction

    task automatic push_result(logic [STATUS_W-1:0] st, int idx, logic with_entry,
                               logic last);
        node_result_t r;
        r = '0;
        r.status = st;
        if (with_entry)
        begin
            r.id      = NODE_W'(idx);
            r.state   = nstate[idx];
            r.prior   = nprior[idx];
            r.misses  = nmiss[idx];
            r.avg     = avg_gap[idx];
            r.longest = max_gap[idx];
        end
        r.last = last;
        expected_results.push_back(r);
    endtask

    task automatic unlist(int idx);
        if (!listed[idx])
            return;
        foreach (recency[i])
        begin
            if (recency[i] == idx)
            begin
                recency.delete(i);
                break;
            end
        end
        listed[idx] = 1'b0;
    endtask

    task automatic make_most_recent(int idx);
        unlist(idx);
        if (recency.size() < NN)
        begin
            recency.push_back(idx);
            listed[idx] = 1'b1;
        end
    endtask

    task automatic take_beat(int idx, logic [TW-1:0] t);
        logic [TW-1:0] gap;
        logic [TW-1:0] a;
        if (beat_stamp[idx] != '0)
        begin
            gap = t - beat_stamp[idx];
            a   = avg_gap[idx];
            if (a != '0)
                avg_gap[idx] = (a >> 1) + (gap >> 1) + TW'(a[0] & gap[0]);
            else
                avg_gap[idx] = gap;
            if (gap > max_gap[idx])
                max_gap[idx] = gap;
        end
        beat_stamp[idx] = t;
        nmiss[idx]      = '0;
        make_most_recent(idx);
    endtask

    task automatic predict_event(logic [MODE_W-1:0] m, int idx, logic [TW-1:0] t);
        int walk[$];
        logic [STATUS_W-1:0] st;
        if ((m >= MODE_LOGIN && m <= MODE_BEAT || m == MODE_QUERY) && !known[idx])
        begin
            push_result(STAT_UNKNOWN, idx, 1'b0, 1'b1);
            return;
        end
        case (m)
            MODE_ADD:
            begin
                if (!known[idx])
                begin
                    known[idx]      = 1'b1;
                    nstate[idx]     = NS_OUT;
                    nprior[idx]     = NS_OUT;
                    nmiss[idx]      = '0;
                    beat_stamp[idx] = '0;
                    avg_gap[idx]    = '0;
                    max_gap[idx]    = '0;
                    unlist(idx);
                end
                push_result(STAT_OK, idx, 1'b1, 1'b1);
            end
            MODE_LOGIN:
            begin
                if (nstate[idx] != NS_OUT && nstate[idx] != NS_OM)
                    push_result(STAT_BAD_CHANGE, idx, 1'b1, 1'b1);
                else
                begin
                    nprior[idx] = nstate[idx];
                    nstate[idx] = NS_IN;
                    make_most_recent(idx);
                    push_result(STAT_OK, idx, 1'b1, 1'b1);
                end
            end
            MODE_LOGOUT, MODE_MARK_EXP:
            begin
                unlist(idx);
                nprior[idx] = nstate[idx];
                nstate[idx] = (m == MODE_LOGOUT) ? NS_OUT : NS_EXP;
                push_result(STAT_OK, idx, 1'b1, 1'b1);
            end
            MODE_FORCE_EXP:
            begin
                nstate[idx] = NS_EXP;
                unlist(idx);
                push_result(STAT_OK, idx, 1'b1, 1'b1);
            end
            MODE_BEAT:
            begin
                if (!is_live(idx))
                    push_result(STAT_NOT_ALLOWED, idx, 1'b1, 1'b1);
                else
                begin
                    take_beat(idx, t);
                    push_result(STAT_OK, idx, 1'b1, 1'b1);
                end
            end
            MODE_CHECK:
            begin
                if (t > last_check && t - last_check > TW'(period >> 1))
                begin
                    last_check = t;
                    walk = recency;
                    foreach (walk[i])
                    begin
                        if (!is_live(walk[i]))
                            continue;
                        // stop at the first node that is on time
                        if (!(t > beat_stamp[walk[i]] &&
                              t - beat_stamp[walk[i]] > TW'(period)))
                            break;
                        if (nmiss[walk[i]] != MISS_MAX)
                            nmiss[walk[i]]++;
                        beat_stamp[walk[i]] = t;
                        make_most_recent(walk[i]);
                        st = STAT_OK;
                        if (nmiss[walk[i]] > allow)
                        begin
                            nstate[walk[i]] = NS_EXP;
                            unlist(walk[i]);
                            st = STAT_EXPIRED;
                        end
                        push_result(st, walk[i], 1'b1, 1'b0);
                    end
                end
                push_result(STAT_OK, 0, 1'b0, 1'b1);
            end
            MODE_BEAT_ALL:
            begin
                for (int i = 0; i < NN; i++)
                begin
                    if (known[i] && is_live(i))
                    begin
                        take_beat(i, t);
                        push_result(STAT_OK, i, 1'b1, 1'b0);
                    end
                end
                push_result(STAT_OK, 0, 1'b0, 1'b1);
            end
            MODE_OLD_MASTER:
            begin
                for (int i = 0; i < NN; i++)
                begin
                    if (known[i] && nstate[i] == NS_IN)
                    begin
                        nprior[i] = NS_IN;
                        nstate[i] = NS_OM;
                    end
                end
                push_result(STAT_OK, 0, 1'b0, 1'b1);
            end
            MODE_QUERY:
                push_result(STAT_OK, idx, 1'b1, 1'b1);
            default:
                push_result(STAT_NOT_ALLOWED, 0, 1'b0, 1'b1);
        endcase
    endtask

    // track register writes and events, compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        node_result_t got;
        node_result_t want;
        if (!rst_n)
        begin
            period     = PERIOD_RESET;
            allow      = ALLOW_RESET;
            last_check = '0;
            recency.delete();
            expected_results.delete();
            for (int i = 0; i < NN; i++)
            begin
                known[i]      = 1'b0;
                nstate[i]     = NS_OUT;
                nprior[i]     = NS_OUT;
                nmiss[i]      = '0;
                beat_stamp[i] = '0;
                avg_gap[i]    = '0;
                max_gap[i]    = '0;
                listed[i]     = 1'b0;
            end
            mismatches   = 0;
            results_seen = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PERIOD)
                    period = cfg_data;
                else if (cfg_index == REG_ALLOW)
                    allow = cfg_data[MISS_W-1:0];
            end
            if (in_valid && in_ready)
                predict_event(mode, node, now);
            if (out_valid && out_ready)
            begin
                results_seen++;
                got = '{status, node_id, node_state, prior_state, miss_count,
                        average_delay, longest_delay, final_res};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: status %0d node %0d",
                                 $realtime, status, node_id);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] result mismatch (status node state prior miss avg max last)",
                                     $realtime);
                            $display("    expected %0d %0d %0d %0d %0d %0d %0d %0d", want.status,
                                     want.id, want.state, want.prior, want.misses, want.avg,
                                     want.longest, want.last);
                            $display("    actual   %0d %0d %0d %0d %0d %0d %0d %0d", got.status,
                                     got.id, got.state, got.prior, got.misses, got.avg,
                                     got.longest, got.last);
                        end
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

### sim/tb_heartbeat_liveness_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heartbeat_liveness_monitor
// Drives membership, beat and check events into the liveness monitor under
// several register settings and idle patterns; the result checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_heartbeat_liveness_monitor;
    import hlm_pkg::*;

    localparam int TW = TIME_BITS_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 4'd15;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [MODE_W-1:0]      mode;
    logic [NODE_W-1:0]      node;
    logic [TW-1:0]          now;
    logic                   out_valid;
    logic                   out_ready;
    logic [STATUS_W-1:0]    status;
    logic [NODE_W-1:0]      node_id;
    logic [NSTATE_W-1:0]    node_state;
    logic [NSTATE_W-1:0]    prior_state;
    logic [MISS_W-1:0]      miss_count;
    logic [TW-1:0]          average_delay;
    logic [TW-1:0]          longest_delay;
    logic                   final_res;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int pending;
    int mismatches;
    int results_seen;
    int events_sent;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    logic [TW-1:0] clock_us;

    heartbeat_liveness_monitor u_dut (.*);

    hlm_result_checker u_checker (.*);

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("tb_heartbeat_liveness_monitor: FAIL");
            $finish;
        end
    end

    // offer one event and hold it until accepted
    task automatic send_event(logic [MODE_W-1:0] m, logic [NODE_W-1:0] n, logic [TW-1:0] t);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        node     <= n;
        now      <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;
    endtask

    // drop valid, wait until every result is back, let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed traffic on a few nodes with advancing time
    task automatic random_events(int count, int period);
        int pick;
        logic [NODE_W-1:0] n;
        logic [TW-1:0] t;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            n = ($urandom_range(3) == 0) ? NODE_W'($urandom) : NODE_W'($urandom_range(7));
            clock_us += $urandom_range(2 * period);
            t = clock_us;
            if ($urandom_range(19) == 0)
                t = TW'({$urandom, $urandom});
            if (pick < 6)
                send_event(MODE_ADD, n, t);
            else if (pick < 16)
                send_event(MODE_LOGIN, n, t);
            else if (pick < 21)
                send_event(MODE_LOGOUT, n, t);
            else if (pick < 24)
                send_event(MODE_MARK_EXP, n, t);
            else if (pick < 27)
                send_event(MODE_FORCE_EXP, n, t);
            else if (pick < 52)
                send_event(MODE_BEAT, n, t);
            else if (pick < 72)
                send_event(MODE_CHECK, n, t);
            else if (pick < 78)
                send_event(MODE_BEAT_ALL, n, t);
            else if (pick < 81)
                send_event(MODE_OLD_MASTER, n, t);
            else if (pick < 95)
                send_event(MODE_QUERY, n, t);
            else
                send_event(MODE_LOGIN + MODE_W'($urandom_range(9, 15)) - MODE_LOGIN, n, t);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_ADD;
        node = '0;
        now = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PERIOD;
        cfg_data = '0;
        cycles = 0;
        events_sent = 0;
        send_idle_pct = 34;
        recv_idle_pct = 58;
        clock_us = 48'd70000000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: membership transitions, errors and time extremes
        send_event(MODE_ADD, 5'd0, '0);
        send_event(MODE_ADD, 5'd31, '0);
        send_event(MODE_ADD, 5'd0, '0);
        send_event(MODE_LOGIN, 5'd5, '0);
        send_event(MODE_QUERY, 5'd7, '0);
        send_event(MODE_LOGIN, 5'd0, '0);
        send_event(MODE_LOGIN, 5'd0, '0);
        send_event(MODE_BEAT, 5'd31, 48'd50);
        send_event(MODE_LOGIN, 5'd31, '0);
        send_event(MODE_BEAT, 5'd0, 48'd100);
        send_event(MODE_BEAT, 5'd0, 48'd300);
        send_event(MODE_BEAT, 5'd0, 48'd7);
        send_event(MODE_BEAT_ALL, 5'd0, {TW{1'b1}});
        send_event(MODE_CHECK, 5'd0, 48'd40000000);
        send_event(MODE_CHECK, 5'd0, 48'd40000001);
        send_event(MODE_OLD_MASTER, 5'd0, '0);
        send_event(MODE_LOGIN, 5'd0, '0);
        send_event(MODE_CHECK, 5'd0, 48'd50000000);
        send_event(MODE_LOGOUT, 5'd31, '0);
        send_event(MODE_MARK_EXP, 5'd0, '0);
        send_event(MODE_LOGIN, 5'd0, '0);
        send_event(MODE_FORCE_EXP, 5'd31, '0);
        send_event(MODE_RESERVED, 5'd3, '0);
        send_event(MODE_QUERY, 5'd0, '0);
        drain();

        // saturate a miss count: shortest period, largest tolerance
        write_reg(REG_PERIOD, 32'd1);
        write_reg(REG_ALLOW, 8'd255);
        send_event(MODE_LOGOUT, 5'd0, '0);
        send_event(MODE_ADD, 5'd9, '0);
        send_event(MODE_LOGIN, 5'd9, '0);
        send_event(MODE_BEAT, 5'd9, 48'd60000000);
        for (int k = 0; k < 258; k++)
            send_event(MODE_CHECK, 5'd9, 48'd60000010 + 48'(2 * k));
        send_event(MODE_QUERY, 5'd9, '0);
        drain();

        // longest period, no tolerance
        write_reg(REG_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_ALLOW, 8'd0);
        random_events(20, 32'h7FFF_FFFF);
        drain();

        // main random traffic across idle patterns
        write_reg(REG_PERIOD, 32'd1000);
        write_reg(REG_ALLOW, 8'd1);
        random_events(40, 1000);
        drain();
        send_idle_pct = 58;
        recv_idle_pct = 34;
        write_reg(REG_ALLOW, 8'd3);
        random_events(40, 1000);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_PERIOD, 32'd400);
        random_events(40, 400);
        in_valid <= 1'b0;

        // wait out the tail
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d events and %0d results over six register settings",
                 events_sent, results_seen);
        $display("idle patterns: sender-heavy, receiver-heavy and none; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending == 0)
            $display("tb_heartbeat_liveness_monitor: PASS");
        else
            $display("tb_heartbeat_liveness_monitor: FAIL");
        $finish;
    end

endmodule
